/* sv/pps_pkg.sv */
`timescale 1ns / 1ps
// shared widths, codes and command/status types of the polygon plane split unit
package pps_pkg;

    // field and internal widths
    localparam int FW = 32;
    localparam int CW = 32;
    localparam int SW = 68;
    localparam int MW = FW + 2;
    localparam int PW = 2 * MW;
    localparam int LW = (SW + 2) / 3;
    localparam int DW = SW + CW + 1;
    localparam int QB = 40;
    localparam int QW = QB + 1;
    localparam int RW = SW + 1;
    localparam int FRAC_N = 30;
    localparam int CFG_IW = 2;

    localparam logic [FW-1:0] PLANE_C_RESET = 32'h4000_0000;
    localparam logic [QW-1:0] QLIM = QW'(1) << QB;

    // register indexes
    localparam logic [CFG_IW-1:0] REG_A = 2'd0;
    localparam logic [CFG_IW-1:0] REG_B = 2'd1;
    localparam logic [CFG_IW-1:0] REG_C = 2'd2;
    localparam logic [CFG_IW-1:0] REG_D = 2'd3;

    // vertex classes
    localparam logic [1:0] CLS_FRONT = 2'd0;
    localparam logic [1:0] CLS_BACK  = 2'd1;
    localparam logic [1:0] CLS_ON    = 2'd2;

    // datapath operations
    localparam logic [3:0] OP_NONE   = 4'd0;
    localparam logic [3:0] OP_LOAD   = 4'd1;
    localparam logic [3:0] OP_SUM    = 4'd2;
    localparam logic [3:0] OP_KEEP   = 4'd3;
    localparam logic [3:0] OP_SETUP1 = 4'd4;
    localparam logic [3:0] OP_SETUP2 = 4'd5;
    localparam logic [3:0] OP_DIFF   = 4'd6;
    localparam logic [3:0] OP_PMUL   = 4'd7;
    localparam logic [3:0] OP_DIVGO  = 4'd8;
    localparam logic [3:0] OP_QSIGN  = 4'd9;
    localparam logic [3:0] OP_FINISH = 4'd10;
    localparam logic [3:0] OP_EMIT   = 4'd11;
    localparam logic [3:0] OP_UPDATE = 4'd12;
    localparam logic [3:0] OP_CLOSE  = 4'd13;

    typedef struct packed {
        logic [3:0] op;
        logic [1:0] stp;
        logic [1:0] ci;
        logic       edge_sel;
        logic       use_other;
        logic       emit_cross;
        logic       emit_side;
        logic       emit_end;
    } pps_cmd_t;

    typedef struct packed {
        logic [1:0] cls;
        logic [1:0] prev_cls;
        logic [1:0] first_cls;
        logic       in_poly;
        logic       last;
        logic       den_zero;
        logic       div_done;
        logic       out_free;
    } pps_stat_t;

endpackage

/* sv/pps_div.sv */
`timescale 1ns / 1ps
// restoring divider, one quotient bit per cycle, with overflow detection
module pps_div (
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     start,
    input  logic [pps_pkg::DW-1:0]   dividend,
    input  logic [pps_pkg::SW-1:0]   divisor,
    output logic                     done,
    output logic [pps_pkg::QW-1:0]   quotient,
    output logic                     overflow
);

    localparam int CNT_W = $clog2(pps_pkg::QW + 1);

    logic                    busy_reg;
    logic [CNT_W-1:0]        cnt_reg;
    logic                    done_reg;
    logic [pps_pkg::RW-1:0]  rem_reg;
    logic [pps_pkg::QW-1:0]  low_reg;
    logic [pps_pkg::QW-1:0]  q_reg;
    logic                    ovf_reg;
    logic [pps_pkg::RW-1:0]  rem_shift;
    logic [pps_pkg::RW-1:0]  dsr_ext;
    logic [pps_pkg::RW-1:0]  top_ext;
    logic                    ge;

    // one trial subtract
    always_comb
    begin
        dsr_ext   = pps_pkg::RW'(divisor);
        top_ext   = pps_pkg::RW'(dividend[pps_pkg::DW-1:pps_pkg::QW]);
        rem_shift = {rem_reg[pps_pkg::RW-2:0], low_reg[pps_pkg::QW-1]};
        ge        = (rem_shift >= dsr_ext);
    end

    // sequencing
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            cnt_reg  <= '0;
            done_reg <= 1'b0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= CNT_W'(pps_pkg::QW);
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg - CNT_W'(1);
                if (cnt_reg == CNT_W'(1))
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    // remainder and quotient
    always_ff @(posedge clk)
    begin
        if (start)
        begin
            rem_reg <= top_ext;
            low_reg <= dividend[pps_pkg::QW-1:0];
            q_reg   <= '0;
            ovf_reg <= (top_ext >= dsr_ext);
        end
        else if (busy_reg)
        begin
            rem_reg <= ge ? (rem_shift - dsr_ext) : rem_shift;
            low_reg <= low_reg << 1;
            q_reg   <= {q_reg[pps_pkg::QW-2:0], ge};
        end
    end

    assign done     = done_reg;
    assign quotient = q_reg;
    assign overflow = ovf_reg;

endmodule

/* sv/pps_datapath.sv */
`timescale 1ns / 1ps
// datapath: plane registers, vertex store, shared multiplier, crossing arithmetic, output
module pps_datapath (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          cfg_write,
    input  logic [pps_pkg::CFG_IW-1:0]    cfg_index,
    input  logic [pps_pkg::FW-1:0]        cfg_data,
    input  logic [pps_pkg::FW-1:0]        vx,
    input  logic [pps_pkg::FW-1:0]        vy,
    input  logic [pps_pkg::FW-1:0]        vz,
    input  logic                          last_vertex,
    input  logic                          out_stall,
    input  pps_pkg::pps_cmd_t             cmd,
    output pps_pkg::pps_stat_t            stat,
    output logic                          out_valid,
    output logic                          side,
    output logic signed [pps_pkg::FW-1:0] out_x,
    output logic signed [pps_pkg::FW-1:0] out_y,
    output logic signed [pps_pkg::FW-1:0] out_z,
    output logic                          end_of_polygon
);

    localparam int CW = pps_pkg::CW;
    localparam int SW = pps_pkg::SW;
    localparam int MW = pps_pkg::MW;
    localparam int PW = pps_pkg::PW;
    localparam int LW = pps_pkg::LW;
    localparam int DW = pps_pkg::DW;
    localparam int QW = pps_pkg::QW;
    localparam logic signed [QW+1:0] SAT_HI =
        (QW+2)'((longint'(1) <<< (CW - 1)) - longint'(1));
    localparam logic signed [QW+1:0] SAT_LO = -SAT_HI - (QW+2)'(1);

    logic signed [pps_pkg::FW-1:0] pa_reg, pb_reg, pc_reg, pd_reg;
    logic signed [CW-1:0] v_reg [3];
    logic signed [CW-1:0] prev_reg [3];
    logic signed [CW-1:0] first_reg [3];
    logic signed [CW-1:0] r_reg [3];
    logic                 last_reg;
    logic [1:0]           cls_reg, prev_cls_reg, first_cls_reg;
    logic                 in_poly_reg;
    logic signed [PW-1:0] prod_reg;
    logic signed [SW-1:0] acc_reg, sv_reg, num_reg, den_reg;
    logic [SW-1:0]        an_reg, ad_reg;
    logic                 neg_nd_reg, dneg_reg;
    logic [CW:0]          md_reg;
    logic [DW-1:0]        dvd_reg;
    logic signed [QW:0]   qv_reg;
    logic                 out_valid_reg, side_reg, end_reg;
    logic signed [pps_pkg::FW-1:0] ox_reg, oy_reg, oz_reg;

    logic signed [CW-1:0] src_c [3];
    logic signed [CW-1:0] a_c, b_c;
    logic signed [MW-1:0] mul_a, mul_b;
    logic [3*LW-1:0]      an_pad;
    logic [LW-1:0]        limb;
    logic signed [SW-1:0] d_shift;
    logic signed [CW:0]   diff_c;
    logic [QW-1:0]        qc;
    logic [QW-1:0]        div_q;
    logic                 div_ovf, div_done;
    logic signed [QW+1:0] sum_c;
    logic signed [QW+1:0] sat_c;
    logic [DW-1:0]        pext;
    logic                 out_free, out_load;

    // operand selection
    always_comb
    begin
        for (int i = 0; i < 3; i++)
        begin
            src_c[i] = !cmd.use_other ? v_reg[i] :
                       (cmd.edge_sel ? first_reg[i] : prev_reg[i]);
        end
        a_c = cmd.edge_sel ? v_reg[cmd.ci] : prev_reg[cmd.ci];
        b_c = cmd.edge_sel ? first_reg[cmd.ci] : v_reg[cmd.ci];
        an_pad = (3*LW)'(an_reg);
        case (cmd.stp)
            2'd0:    limb = an_pad[LW-1:0];
            2'd1:    limb = an_pad[2*LW-1:LW];
            default: limb = an_pad[3*LW-1:2*LW];
        endcase
        if (cmd.op == pps_pkg::OP_PMUL)
        begin
            mul_a = $signed(MW'(limb));
            mul_b = $signed(MW'(md_reg));
        end
        else
        begin
            case (cmd.stp)
                2'd0:
                begin
                    mul_a = MW'(pa_reg);
                    mul_b = MW'(src_c[0]);
                end
                2'd1:
                begin
                    mul_a = MW'(pb_reg);
                    mul_b = MW'(src_c[1]);
                end
                default:
                begin
                    mul_a = MW'(pc_reg);
                    mul_b = MW'(src_c[2]);
                end
            endcase
        end
    end

    // misc arithmetic
    always_comb
    begin
        d_shift = SW'(pd_reg) <<< pps_pkg::FRAC_N;
        diff_c  = (CW+1)'(b_c) - (CW+1)'(a_c);
        pext    = DW'($unsigned(prod_reg));
        qc      = (div_ovf || (div_q > pps_pkg::QLIM)) ? pps_pkg::QLIM : div_q;
        sum_c   = (QW+2)'(a_c) + (QW+2)'(qv_reg);
        if (sum_c > SAT_HI)
            sat_c = SAT_HI;
        else if (sum_c < SAT_LO)
            sat_c = SAT_LO;
        else
            sat_c = sum_c;
        out_free = !out_valid_reg || !out_stall;
        out_load = (cmd.op == pps_pkg::OP_EMIT) && out_free;
    end

    // divider
    pps_div u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (cmd.op == pps_pkg::OP_DIVGO),
        .dividend (dvd_reg),
        .divisor  (ad_reg),
        .done     (div_done),
        .quotient (div_q),
        .overflow (div_ovf)
    );

    // plane registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pa_reg <= '0;
            pb_reg <= '0;
            pc_reg <= pps_pkg::PLANE_C_RESET;
            pd_reg <= '0;
        end
        else if (cfg_write)
        begin
            case (cfg_index)
                pps_pkg::REG_A: pa_reg <= cfg_data;
                pps_pkg::REG_B: pb_reg <= cfg_data;
                pps_pkg::REG_C: pc_reg <= cfg_data;
                pps_pkg::REG_D: pd_reg <= cfg_data;
                default: ;
            endcase
        end
    end

    // polygon state and output valid
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cls_reg       <= pps_pkg::CLS_FRONT;
            prev_cls_reg  <= pps_pkg::CLS_FRONT;
            first_cls_reg <= pps_pkg::CLS_FRONT;
            in_poly_reg   <= 1'b0;
            out_valid_reg <= 1'b0;
            for (int i = 0; i < 3; i++)
            begin
                prev_reg[i]  <= '0;
                first_reg[i] <= '0;
            end
        end
        else
        begin
            if (out_load)
                out_valid_reg <= 1'b1;
            else if (out_free)
                out_valid_reg <= 1'b0;
            case (cmd.op)
                pps_pkg::OP_KEEP:
                begin
                    if (acc_reg < 0)
                        cls_reg <= pps_pkg::CLS_BACK;
                    else if (acc_reg == '0)
                        cls_reg <= pps_pkg::CLS_ON;
                    else
                        cls_reg <= pps_pkg::CLS_FRONT;
                end
                pps_pkg::OP_UPDATE:
                begin
                    for (int i = 0; i < 3; i++)
                        prev_reg[i] <= v_reg[i];
                    prev_cls_reg <= cls_reg;
                    if (!in_poly_reg)
                    begin
                        for (int i = 0; i < 3; i++)
                            first_reg[i] <= v_reg[i];
                        first_cls_reg <= cls_reg;
                        in_poly_reg   <= 1'b1;
                    end
                end
                pps_pkg::OP_CLOSE:
                begin
                    if (last_reg)
                        in_poly_reg <= 1'b0;
                end
                default: ;
            endcase
        end
    end

    // arithmetic registers
    always_ff @(posedge clk)
    begin
        prod_reg <= mul_a * mul_b;
        case (cmd.op)
            pps_pkg::OP_LOAD:
            begin
                v_reg[0] <= $signed(vx[CW-1:0]);
                v_reg[1] <= $signed(vy[CW-1:0]);
                v_reg[2] <= $signed(vz[CW-1:0]);
                last_reg <= last_vertex;
            end
            pps_pkg::OP_SUM:
            begin
                if (cmd.stp == 2'd0)
                    acc_reg <= d_shift;
                else
                    acc_reg <= acc_reg + SW'(prod_reg);
            end
            pps_pkg::OP_KEEP:
                sv_reg <= acc_reg;
            pps_pkg::OP_SETUP1:
            begin
                if (cmd.edge_sel)
                begin
                    num_reg <= sv_reg;
                    den_reg <= sv_reg - acc_reg;
                end
                else
                begin
                    num_reg <= acc_reg;
                    den_reg <= acc_reg - sv_reg;
                end
            end
            pps_pkg::OP_SETUP2:
            begin
                an_reg     <= num_reg[SW-1] ? SW'(-num_reg) : SW'(num_reg);
                ad_reg     <= den_reg[SW-1] ? SW'(-den_reg) : SW'(den_reg);
                neg_nd_reg <= num_reg[SW-1] ^ den_reg[SW-1];
            end
            pps_pkg::OP_DIFF:
            begin
                md_reg   <= diff_c[CW] ? (CW+1)'(-diff_c) : (CW+1)'(diff_c);
                dneg_reg <= diff_c[CW];
            end
            pps_pkg::OP_PMUL:
            begin
                case (cmd.stp)
                    2'd0:    dvd_reg <= '0;
                    2'd1:    dvd_reg <= dvd_reg + pext;
                    2'd2:    dvd_reg <= dvd_reg + (pext << LW);
                    default: dvd_reg <= dvd_reg + (pext << (2 * LW));
                endcase
            end
            pps_pkg::OP_QSIGN:
            begin
                if (neg_nd_reg ^ dneg_reg)
                    qv_reg <= -$signed({1'b0, qc});
                else
                    qv_reg <= $signed({1'b0, qc});
            end
            pps_pkg::OP_FINISH:
                r_reg[cmd.ci] <= CW'(sat_c);
            default: ;
        endcase
    end

    // output register
    always_ff @(posedge clk)
    begin
        if (out_load)
        begin
            side_reg <= cmd.emit_side;
            end_reg  <= cmd.emit_end;
            ox_reg   <= pps_pkg::FW'(cmd.emit_cross ? r_reg[0] : v_reg[0]);
            oy_reg   <= pps_pkg::FW'(cmd.emit_cross ? r_reg[1] : v_reg[1]);
            oz_reg   <= pps_pkg::FW'(cmd.emit_cross ? r_reg[2] : v_reg[2]);
        end
    end

    // status to controller
    always_comb
    begin
        stat.cls       = cls_reg;
        stat.prev_cls  = prev_cls_reg;
        stat.first_cls = first_cls_reg;
        stat.in_poly   = in_poly_reg;
        stat.last      = last_reg;
        stat.den_zero  = (den_reg == '0);
        stat.div_done  = div_done;
        stat.out_free  = out_free;
    end

    assign out_valid      = out_valid_reg;
    assign side           = side_reg;
    assign out_x          = ox_reg;
    assign out_y          = oy_reg;
    assign out_z          = oz_reg;
    assign end_of_polygon = end_reg;

endmodule

/* sv/pps_ctrl.sv */
`timescale 1ns / 1ps
// controller: sequences classification, crossing computation and emission per vertex
module pps_ctrl (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_stall,
    input  pps_pkg::pps_stat_t stat,
    output pps_pkg::pps_cmd_t  cmd
);

    localparam logic [4:0] S_IDLE  = 5'd0;
    localparam logic [4:0] S_SUMV  = 5'd1;
    localparam logic [4:0] S_KEEP  = 5'd2;
    localparam logic [4:0] S_EDGE  = 5'd3;
    localparam logic [4:0] S_SUMO  = 5'd4;
    localparam logic [4:0] S_SET1  = 5'd5;
    localparam logic [4:0] S_SET2  = 5'd6;
    localparam logic [4:0] S_DIFF  = 5'd7;
    localparam logic [4:0] S_PMUL  = 5'd8;
    localparam logic [4:0] S_DIVGO = 5'd9;
    localparam logic [4:0] S_DIVW  = 5'd10;
    localparam logic [4:0] S_QSGN  = 5'd11;
    localparam logic [4:0] S_FIN   = 5'd12;
    localparam logic [4:0] S_EMXF  = 5'd13;
    localparam logic [4:0] S_EMXB  = 5'd14;
    localparam logic [4:0] S_UPD   = 5'd15;
    localparam logic [4:0] S_CCHK  = 5'd16;
    localparam logic [4:0] S_EMV1  = 5'd17;
    localparam logic [4:0] S_EMV2  = 5'd18;
    localparam logic [4:0] S_CLOSE = 5'd19;

    logic [4:0] state_reg, state_next;
    logic [1:0] stp_reg, stp_next;
    logic [1:0] ci_reg, ci_next;
    logic       edge_sel_reg, edge_sel_next;
    logic       close_go_reg, close_go_next;

    // ends strictly on opposite sides
    function automatic logic opposite(input logic [1:0] p, input logic [1:0] q);
        return (p != pps_pkg::CLS_ON) && (q != pps_pkg::CLS_ON) && (p != q);
    endfunction

    // next state and commands
    always_comb
    begin
        state_next    = state_reg;
        stp_next      = stp_reg;
        ci_next       = ci_reg;
        edge_sel_next = edge_sel_reg;
        close_go_next = close_go_reg;
        cmd           = '0;
        cmd.op        = pps_pkg::OP_NONE;
        cmd.stp       = stp_reg;
        cmd.ci        = ci_reg;
        cmd.edge_sel  = edge_sel_reg;
        in_stall      = (state_reg != S_IDLE);
        case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.op        = pps_pkg::OP_LOAD;
                    state_next    = S_SUMV;
                    stp_next      = 2'd0;
                    close_go_next = 1'b0;
                end
            end
            S_SUMV:
            begin
                cmd.op   = pps_pkg::OP_SUM;
                stp_next = stp_reg + 2'd1;
                if (stp_reg == 2'd3)
                    state_next = S_KEEP;
            end
            S_KEEP:
            begin
                cmd.op     = pps_pkg::OP_KEEP;
                state_next = S_EDGE;
            end
            S_EDGE:
            begin
                if (stat.in_poly && opposite(stat.cls, stat.prev_cls))
                begin
                    edge_sel_next = 1'b0;
                    state_next    = S_SUMO;
                end
                else
                    state_next = S_UPD;
            end
            S_SUMO:
            begin
                cmd.op        = pps_pkg::OP_SUM;
                cmd.use_other = 1'b1;
                stp_next      = stp_reg + 2'd1;
                if (stp_reg == 2'd3)
                    state_next = S_SET1;
            end
            S_SET1:
            begin
                cmd.op     = pps_pkg::OP_SETUP1;
                state_next = S_SET2;
            end
            S_SET2:
            begin
                cmd.op = pps_pkg::OP_SETUP2;
                if (edge_sel_reg)
                begin
                    close_go_next = !stat.den_zero;
                    state_next    = S_EMV1;
                end
                else if (stat.den_zero)
                    state_next = S_UPD;
                else
                begin
                    ci_next    = 2'd0;
                    state_next = S_DIFF;
                end
            end
            S_DIFF:
            begin
                cmd.op     = pps_pkg::OP_DIFF;
                stp_next   = 2'd0;
                state_next = S_PMUL;
            end
            S_PMUL:
            begin
                cmd.op   = pps_pkg::OP_PMUL;
                stp_next = stp_reg + 2'd1;
                if (stp_reg == 2'd3)
                    state_next = S_DIVGO;
            end
            S_DIVGO:
            begin
                cmd.op     = pps_pkg::OP_DIVGO;
                state_next = S_DIVW;
            end
            S_DIVW:
            begin
                if (stat.div_done)
                    state_next = S_QSGN;
            end
            S_QSGN:
            begin
                cmd.op     = pps_pkg::OP_QSIGN;
                state_next = S_FIN;
            end
            S_FIN:
            begin
                cmd.op = pps_pkg::OP_FINISH;
                if (ci_reg == 2'd2)
                    state_next = S_EMXF;
                else
                begin
                    ci_next    = ci_reg + 2'd1;
                    state_next = S_DIFF;
                end
            end
            S_EMXF:
            begin
                cmd.op         = pps_pkg::OP_EMIT;
                cmd.emit_cross = 1'b1;
                if (stat.out_free)
                    state_next = S_EMXB;
            end
            S_EMXB:
            begin
                cmd.op         = pps_pkg::OP_EMIT;
                cmd.emit_cross = 1'b1;
                cmd.emit_side  = 1'b1;
                cmd.emit_end   = edge_sel_reg;
                if (stat.out_free)
                    state_next = edge_sel_reg ? S_CLOSE : S_UPD;
            end
            S_UPD:
            begin
                cmd.op     = pps_pkg::OP_UPDATE;
                state_next = S_CCHK;
            end
            S_CCHK:
            begin
                if (stat.last && opposite(stat.cls, stat.first_cls))
                begin
                    edge_sel_next = 1'b1;
                    state_next    = S_SUMO;
                end
                else
                    state_next = S_EMV1;
            end
            S_EMV1:
            begin
                cmd.op        = pps_pkg::OP_EMIT;
                cmd.emit_side = (stat.cls == pps_pkg::CLS_BACK);
                cmd.emit_end  = stat.last && (stat.cls != pps_pkg::CLS_ON) && !close_go_reg;
                if (stat.out_free)
                begin
                    if (stat.cls == pps_pkg::CLS_ON)
                        state_next = S_EMV2;
                    else if (close_go_reg)
                    begin
                        ci_next    = 2'd0;
                        state_next = S_DIFF;
                    end
                    else
                        state_next = S_CLOSE;
                end
            end
            S_EMV2:
            begin
                cmd.op        = pps_pkg::OP_EMIT;
                cmd.emit_side = 1'b1;
                cmd.emit_end  = stat.last;
                if (stat.out_free)
                    state_next = S_CLOSE;
            end
            S_CLOSE:
            begin
                cmd.op     = pps_pkg::OP_CLOSE;
                state_next = S_IDLE;
            end
            default:
                state_next = S_IDLE;
        endcase
    end

    // state registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= S_IDLE;
            stp_reg      <= 2'd0;
            ci_reg       <= 2'd0;
            edge_sel_reg <= 1'b0;
            close_go_reg <= 1'b0;
        end
        else
        begin
            state_reg    <= state_next;
            stp_reg      <= stp_next;
            ci_reg       <= ci_next;
            edge_sel_reg <= edge_sel_next;
            close_go_reg <= close_go_next;
        end
    end

    // checks
    a_accept_starts_sum: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && !in_stall) |=> (state_reg == S_SUMV && stp_reg == 2'd0))
        else $error("accepted transaction did not start classification");

    a_close_only_closing: assert property (@(posedge clk) disable iff (!rst_n)
        close_go_reg |-> edge_sel_reg)
        else $error("closing crossing flagged on the wrong edge");

    a_second_copy_on_plane: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_EMV2) |-> (stat.cls == pps_pkg::CLS_ON))
        else $error("second vertex copy for a vertex off the plane");

    a_coord_index: assert property (@(posedge clk) disable iff (!rst_n)
        ci_reg != 2'd3)
        else $error("coordinate index out of range");

endmodule

/* sv/polygon_plane_split_unit.sv */
`timescale 1ns / 1ps
// top level of the polygon plane split unit
//
//  channel | signals                                 | handshake
//  --------+-----------------------------------------+------------------------
//  input   | vx vy vz last_vertex                    | in_valid / in_stall
//  output  | side out_x out_y out_z end_of_polygon   | out_valid / out_stall
//  config  | cfg_index cfg_data                      | cfg_write, no wait
//
// one vertex at a time: the class is registered in S_KEEP after the accepting LOAD and
// the plane sum steps of S_SUMV; a vertex that lies on the plane is emitted twice
// each crossing adds the sum, setup and emit steps and waits on the 41-step restoring
// divider run once per coordinate, plus output waits
// reset is asynchronous and active low; it restores the plane to z = 0 and no polygon open
// in_stall is high while a vertex is worked on; out_stall on a full output register
// stalls only the emit steps
module polygon_plane_split_unit (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          cfg_write,
    input  logic [pps_pkg::CFG_IW-1:0]    cfg_index,
    input  logic [pps_pkg::FW-1:0]        cfg_data,
    input  logic                          in_valid,
    output logic                          in_stall,
    input  logic [pps_pkg::FW-1:0]        vx,
    input  logic [pps_pkg::FW-1:0]        vy,
    input  logic [pps_pkg::FW-1:0]        vz,
    input  logic                          last_vertex,
    output logic                          out_valid,
    input  logic                          out_stall,
    output logic                          side,
    output logic signed [pps_pkg::FW-1:0] out_x,
    output logic signed [pps_pkg::FW-1:0] out_y,
    output logic signed [pps_pkg::FW-1:0] out_z,
    output logic                          end_of_polygon
);

    pps_pkg::pps_cmd_t  cmd;
    pps_pkg::pps_stat_t stat;

    // sequencer
    pps_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_stall (in_stall),
        .stat     (stat),
        .cmd      (cmd)
    );

    // arithmetic and storage
    pps_datapath u_datapath (
        .clk            (clk),
        .rst_n          (rst_n),
        .cfg_write      (cfg_write),
        .cfg_index      (cfg_index),
        .cfg_data       (cfg_data),
        .vx             (vx),
        .vy             (vy),
        .vz             (vz),
        .last_vertex    (last_vertex),
        .out_stall      (out_stall),
        .cmd            (cmd),
        .stat           (stat),
        .out_valid      (out_valid),
        .side           (side),
        .out_x          (out_x),
        .out_y          (out_y),
        .out_z          (out_z),
        .end_of_polygon (end_of_polygon)
    );

endmodule

/* test/testbench.sv */
`timescale 1ns / 1ps
// self-checking testbench of the polygon plane split unit
module testbench;

    typedef logic signed [pps_pkg::FW-1:0] coord_t;
    typedef coord_t vert_t [3];
    typedef logic signed [69:0] dist_t;

    typedef struct {
        logic   side;
        coord_t x;
        coord_t y;
        coord_t z;
        logic   eop;
    } piece_vertex_t;

    localparam int STALL_LIMIT = 20000;

    logic           clk;
    logic           rst_n;
    logic           cfg_write;
    logic [pps_pkg::CFG_IW-1:0] cfg_index;
    logic [pps_pkg::FW-1:0]  cfg_data;
    logic           in_valid;
    logic           in_stall;
    logic [pps_pkg::FW-1:0]  vx;
    logic [pps_pkg::FW-1:0]  vy;
    logic [pps_pkg::FW-1:0]  vz;
    logic           last_vertex;
    logic           out_valid;
    logic           out_stall;
    logic           side;
    logic signed [pps_pkg::FW-1:0] out_x;
    logic signed [pps_pkg::FW-1:0] out_y;
    logic signed [pps_pkg::FW-1:0] out_z;
    logic           end_of_polygon;

    // plane mirror and polygon state
    logic [pps_pkg::FW-1:0]  pl_a;
    logic [pps_pkg::FW-1:0]  pl_b;
    logic [pps_pkg::FW-1:0]  pl_c;
    logic [pps_pkg::FW-1:0]  pl_d;
    vert_t          first_vert;
    logic [1:0]     first_cls;
    vert_t          prev_vert;
    logic [1:0]     prev_cls;
    logic           poly_open;

    piece_vertex_t  pending_q [$];
    int             errors;
    int             idle_cycles;
    bit             quiet;

    polygon_plane_split_unit dut (.*);

    always
    begin
        clk = 1'b0;
        #4;
        clk = 1'b1;
        #4;
    end

    // gap length: mostly none or short, a few long
    function automatic int gap_len();
        int r;
        r = $urandom_range(0, 99);
        if (quiet || r < 50)
            return 0;
        else if (r < 90)
            return $urandom_range(1, 3);
        return $urandom_range(10, 40);
    endfunction

    // signed distance of a vertex to the plane, scaled by 2^30
    function automatic dist_t plane_dist(vert_t v);
        dist_t s;
        s = dist_t'($signed(pl_a)) * dist_t'(v[0]) + dist_t'($signed(pl_b)) * dist_t'(v[1])
          + dist_t'($signed(pl_c)) * dist_t'(v[2]) + dist_t'($signed(pl_d)) * 70'sd1073741824;
        return s;
    endfunction

    function automatic logic [1:0] vert_class(vert_t v);
        dist_t s;
        s = plane_dist(v);
        if (s < 0)
            return pps_pkg::CLS_BACK;
        else if (s == 0)
            return pps_pkg::CLS_ON;
        return pps_pkg::CLS_FRONT;
    endfunction

    // interpolated crossing of edge a -> b; returns 0 on a zero denominator
    function automatic bit edge_crossing(vert_t a, vert_t b, output vert_t r);
        dist_t num;
        dist_t den;
        logic [127:0] an;
        logic [127:0] ad;
        logic [127:0] q;
        longint diff;
        longint md;
        longint qv;
        longint sum;
        bit neg;
        num = plane_dist(a);
        den = num - plane_dist(b);
        if (den == 0)
            return 0;
        neg = num[69] ^ den[69];
        an = num < 0 ? 128'(-num) : 128'(num);
        ad = den < 0 ? 128'(-den) : 128'(den);
        for (int i = 0; i < 3; i++)
        begin
            diff = longint'(b[i]) - longint'(a[i]);
            md = diff < 0 ? -diff : diff;
            q = (an * 128'(md)) / ad;
            if (q > (128'd1 << pps_pkg::QB))
                q = 128'd1 << pps_pkg::QB;
            qv = longint'(q[63:0]);
            if (neg != (diff < 0))
                qv = -qv;
            sum = longint'(a[i]) + qv;
            if (sum > 64'sd2147483647)
                sum = 64'sd2147483647;
            else if (sum < -64'sd2147483648)
                sum = -64'sd2147483648;
            r[i] = coord_t'(sum);
        end
        return 1;
    endfunction

    function automatic void push_piece(logic s, vert_t v);
        piece_vertex_t e;
        e.side = s;
        e.x = v[0];
        e.y = v[1];
        e.z = v[2];
        e.eop = 1'b0;
        pending_q = {pending_q, e};
    endfunction

    function automatic void push_both(vert_t v);
        push_piece(1'b0, v);
        push_piece(1'b1, v);
    endfunction

    // expected pieces for one accepted vertex
    function automatic void split_vertex(vert_t v, logic last);
        logic [1:0] cls;
        vert_t x;
        cls = vert_class(v);
        if (!poly_open)
        begin
            first_vert = v;
            first_cls = cls;
            poly_open = 1'b1;
        end
        else if (cls != pps_pkg::CLS_ON && prev_cls != pps_pkg::CLS_ON && cls != prev_cls)
        begin
            if (edge_crossing(prev_vert, v, x))
                push_both(x);
        end
        if (cls == pps_pkg::CLS_ON)
            push_both(v);
        else
            push_piece(cls == pps_pkg::CLS_FRONT ? 1'b0 : 1'b1, v);
        prev_vert = v;
        prev_cls = cls;
        if (last)
        begin
            if (cls != pps_pkg::CLS_ON && first_cls != pps_pkg::CLS_ON && cls != first_cls)
            begin
                if (edge_crossing(v, first_vert, x))
                    push_both(x);
            end
            pending_q[pending_q.size() - 1].eop = 1'b1;
            poly_open = 1'b0;
        end
    endfunction

    // send one vertex transaction
    task automatic send_vertex(coord_t x, coord_t y, coord_t z, logic last);
        vert_t v;
        int gap;
        v[0] = x;
        v[1] = y;
        v[2] = z;
        gap = gap_len();
        if (gap > 0)
        begin
            in_valid = 1'b0;
            repeat (gap) @(negedge clk);
        end
        vx = x;
        vy = y;
        vz = z;
        last_vertex = last;
        in_valid = 1'b1;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        split_vertex(v, last);
        @(negedge clk);
    endtask

    // wait until every expected piece has arrived and the unit is quiet
    task automatic drain();
        @(negedge clk);
        in_valid = 1'b0;
        while (pending_q.size() != 0)
            @(negedge clk);
        repeat (40) @(negedge clk);
    endtask

    task automatic write_reg(logic [pps_pkg::CFG_IW-1:0] idx, logic [pps_pkg::FW-1:0] val);
        drain();
        cfg_write = 1'b1;
        cfg_index = idx;
        cfg_data = val;
        case (idx)
            pps_pkg::REG_A: pl_a = val;
            pps_pkg::REG_B: pl_b = val;
            pps_pkg::REG_C: pl_c = val;
            default: pl_d = val;
        endcase
        @(negedge clk);
        cfg_write = 1'b0;
    endtask

    task automatic set_plane(logic [pps_pkg::FW-1:0] a, logic [pps_pkg::FW-1:0] b,
                             logic [pps_pkg::FW-1:0] c, logic [pps_pkg::FW-1:0] d);
        write_reg(pps_pkg::REG_A, a);
        write_reg(pps_pkg::REG_B, b);
        write_reg(pps_pkg::REG_C, c);
        write_reg(pps_pkg::REG_D, d);
    endtask

    function automatic coord_t rand_coord(bit narrow);
        if (narrow)
            return coord_t'($urandom_range(0, 32'h000f_ffff)) - 32'sh0008_0000;
        return coord_t'($urandom);
    endfunction

    function automatic logic [pps_pkg::FW-1:0] rand_reg();
        case ($urandom_range(0, 5))
            0: return 32'h8000_0000;
            1: return 32'h7fff_ffff;
            2: return 32'h0;
            3: return $urandom_range(0, 32'h0001_ffff) - 32'h0001_0000;
            default: return $urandom;
        endcase
    endfunction

    task automatic send_polygon(int n, bit narrow);
        for (int i = 0; i < n; i++)
            send_vertex(rand_coord(narrow), rand_coord(narrow), rand_coord(narrow), i == n - 1);
    endtask

    // crossings against the reset plane z = 0, on-plane vertices, one-vertex polygon
    task automatic test_reset_plane();
        send_vertex(32'sh0001_0000, 32'sh0002_0000, 32'sh0001_0000, 1'b0);
        send_vertex(-32'sh0003_0000, 32'sh0005_0000, -32'sh0003_0000, 1'b0);
        send_vertex(32'sh0004_0000, 32'sh0000_0000, 32'sh0000_0000, 1'b0);
        send_vertex(32'sh0000_8000, -32'sh0001_0000, -32'sh0000_0001, 1'b1);
        send_vertex(32'sh0000_1234, 32'sh0000_5678, 32'sh0000_0001, 1'b1);
        send_vertex(32'sh0000_1234, 32'sh0000_5678, 32'sh0000_0000, 1'b1);
    endtask

    // extreme coordinates with saturating interpolation
    task automatic test_extremes();
        set_plane(32'h4000_0000, 32'h8000_0000, 32'h7fff_ffff, 32'h8000_0000);
        send_vertex(32'sh7fff_ffff, 32'sh8000_0000, 32'sh7fff_ffff, 1'b0);
        send_vertex(32'sh8000_0000, 32'sh7fff_ffff, 32'sh8000_0000, 1'b0);
        send_vertex(32'sh0, 32'sh0, 32'sh0, 1'b0);
        send_vertex(32'sh8000_0000, 32'sh8000_0000, 32'sh8000_0000, 1'b1);
        set_plane(32'h7fff_ffff, 32'h7fff_ffff, 32'h8000_0000, 32'h7fff_ffff);
        send_vertex(32'sh7fff_ffff, 32'sh7fff_ffff, 32'sh7fff_ffff, 1'b0);
        send_vertex(32'sh8000_0000, 32'sh8000_0000, 32'sh7fff_ffff, 1'b1);
    endtask

    // plane changed mid-polygon: zero denominator, then clamped quotient
    task automatic test_plane_change();
        set_plane(32'h0, 32'h0, 32'h4000_0000, 32'h0);
        send_vertex(32'sh10, 32'sh20, -32'sh0001_0000, 1'b0);
        set_plane(32'h0, 32'h0, 32'h0, 32'h0001_0000);
        send_vertex(32'sh30, 32'sh40, 32'sh50, 1'b1);
        set_plane(32'h0, 32'h0, 32'h4000_0000, 32'h0);
        send_vertex(32'sd1000, 32'sh8000_0000, -32'sh0001_0000, 1'b0);
        set_plane(32'h4000_0000, 32'h0, 32'h0, 32'h0);
        send_vertex(32'sd1001, 32'sh7fff_ffff, 32'sh0001_0000, 1'b1);
    endtask

    // random polygons under a series of planes
    task automatic test_random();
        int sent;
        int n;
        sent = 0;
        while (sent < 440)
        begin
            if ($urandom_range(0, 3) == 0)
                set_plane(rand_reg(), rand_reg(), rand_reg(), rand_reg());
            quiet = ($urandom_range(0, 4) == 0);
            n = ($urandom_range(0, 7) == 0) ? $urandom_range(1, 8) : $urandom_range(3, 5);
            if ($urandom_range(0, 9) == 0)
            begin
                // plane swapped part way through the polygon
                send_vertex(rand_coord(0), rand_coord(0), rand_coord(0), 1'b0);
                write_reg(2'($urandom_range(0, 3)), rand_reg());
                send_vertex(rand_coord(0), rand_coord(0), rand_coord(0), 1'b1);
                n = 2;
            end
            else
                send_polygon(n, $urandom_range(0, 1));
            sent += n;
        end
        quiet = 0;
    endtask

    // result stall pattern
    initial
    begin
        out_stall = 1'b0;
        forever
        begin
            int n;
            n = gap_len();
            @(negedge clk);
            if (n > 0)
            begin
                out_stall = 1'b1;
                repeat (n) @(negedge clk);
                out_stall = 1'b0;
            end
            repeat ($urandom_range(1, 8)) @(negedge clk);
        end
    end

    // compare each result transaction with the oldest expected piece vertex
    always @(posedge clk)
    begin
        piece_vertex_t e;
        if (rst_n && out_valid && !out_stall)
        begin
            if (pending_q.size() == 0)
            begin
                $display("%0t: unexpected result side=%0b x=%h y=%h z=%h eop=%0b", $time,
                         side, out_x, out_y, out_z, end_of_polygon);
                errors++;
            end
            else
            begin
                e = pending_q.pop_front();
                if (e.side !== side || e.x !== out_x || e.y !== out_y || e.z !== out_z
                    || e.eop !== end_of_polygon)
                begin
                    $display("%0t: mismatch expected side=%0b x=%h y=%h z=%h eop=%0b", $time,
                             e.side, e.x, e.y, e.z, e.eop);
                    $display("%0t:          actual   side=%0b x=%h y=%h z=%h eop=%0b", $time,
                             side, out_x, out_y, out_z, end_of_polygon);
                    errors++;
                end
            end
        end
    end

    // watchdog on cycles without any transaction
    always @(posedge clk)
    begin
        if ((in_valid && !in_stall) || (out_valid && !out_stall) || !rst_n)
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= STALL_LIMIT)
        begin
            $display("*** FAILED ***");
            $finish;
        end
    end

    initial
    begin
        rst_n = 1'b0;
        cfg_write = 1'b0;
        cfg_index = '0;
        cfg_data = '0;
        in_valid = 1'b0;
        vx = '0;
        vy = '0;
        vz = '0;
        last_vertex = 1'b0;
        errors = 0;
        idle_cycles = 0;
        quiet = 0;
        pl_a = '0;
        pl_b = '0;
        pl_c = pps_pkg::PLANE_C_RESET;
        pl_d = '0;
        first_vert = '{default: '0};
        prev_vert = '{default: '0};
        first_cls = pps_pkg::CLS_FRONT;
        prev_cls = pps_pkg::CLS_FRONT;
        poly_open = 1'b0;
        repeat (12) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        test_reset_plane();
        test_extremes();
        test_plane_change();
        test_random();
        drain();

        if (errors == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

endmodule
